/* src/rtwc_pkg.sv */
`default_nettype none

package rtwc_pkg;

  localparam int MAX_NODES_DEF = 128;
  localparam int NODE_W        = 7;
  localparam int VAL_W         = 24;
  localparam int SUM_W         = 32;
  localparam int MID_DEPTH     = 4;
  localparam int OUT_DEPTH     = 4;

  localparam logic [VAL_W-1:0] CAP_RESET = 24'd51200;

  typedef enum logic [1:0] {
    CMD_TRAVEL = 2'd0,
    CMD_ATTR   = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_TRAVEL = 2'd0,
    OP_ATTR   = 2'd1,
    OP_STOP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LATE = 2'd1,
    ST_OVER = 2'd2
  } status_e;

  // Attribute word order: 0 open, 1 close, 2 service, 3 demand.
  // A travel write carries its value in word 0.
  typedef struct packed {
    op_e                   kind;
    logic [NODE_W-1:0]     node;
    logic [NODE_W-1:0]     peer;
    logic                  node_ok;
    logic                  peer_ok;
    logic                  last;
    logic [3:0][VAL_W-1:0] data;
  } op_t;

  typedef struct packed {
    status_e           status;
    logic [SUM_W-1:0]  cost;
    logic [SUM_W-1:0]  finish;
    logic [SUM_W-1:0]  load;
  } res_t;

endpackage

`default_nettype wire

/* src/rtwc_fifo.sv */
`default_nettype none

module rtwc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire logic [WIDTH-1:0]         data_i,
  input  wire logic                     pop_i,
  output logic      [WIDTH-1:0]         data_o,
  output logic                          full_o,
  output logic                          empty_o,
  output logic      [$clog2(DEPTH):0]   count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH) + 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* src/rtwc_front.sv */
`default_nettype none

module rtwc_front
  import rtwc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic               push_i,
  input  wire logic               queue_full_i,
  input  wire logic [1:0]         command_i,
  input  wire logic [NODE_W-1:0]  node_i,
  input  wire logic [NODE_W-1:0]  peer_node_i,
  input  wire logic [VAL_W-1:0]   travel_value_i,
  input  wire logic [VAL_W-1:0]   window_open_i,
  input  wire logic [VAL_W-1:0]   window_close_i,
  input  wire logic [VAL_W-1:0]   service_duration_i,
  input  wire logic [VAL_W-1:0]   node_demand_i,
  input  wire logic               last_stop_i,
  output logic                    full_o,
  output logic                    op_valid_o,
  output op_t                     op_o
);

  // Nodes are 7 bits wide, so at most 128 of them can ever be named.
  localparam int N_EFF = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
  localparam logic [NODE_W:0] NODE_LIMIT = (NODE_W + 1)'(N_EFF);

  logic accept;

  assign full_o = queue_full_i;
  assign accept = push_i && !queue_full_i;

  always_comb begin
    op_valid_o = 1'b0;
    op_o.kind    = OP_STOP;
    op_o.node    = node_i;
    op_o.peer    = peer_node_i;
    op_o.node_ok = ({1'b0, node_i} < NODE_LIMIT);
    op_o.peer_ok = ({1'b0, peer_node_i} < NODE_LIMIT);
    op_o.last    = last_stop_i;
    op_o.data    = {window_open_i, window_close_i, service_duration_i, node_demand_i};
    case (cmd_e'(command_i))
      CMD_TRAVEL: begin
        op_valid_o = accept;
        op_o.kind  = OP_TRAVEL;
        op_o.data  = {{(3 * VAL_W){1'b0}}, travel_value_i};
      end
      CMD_ATTR: begin
        op_valid_o = accept;
        op_o.kind  = OP_ATTR;
        op_o.data  = {node_demand_i, service_duration_i, window_close_i, window_open_i};
      end
      CMD_STOP: begin
        op_valid_o = accept;
        op_o.kind  = OP_STOP;
      end
      default: begin
        // unused command: take the item and drop it
        op_valid_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rtwc_back.sv */
`default_nettype none

module rtwc_back
  import rtwc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [VAL_W-1:0]   cfg_wdata_i,
  input  wire logic               op_empty_i,
  input  wire op_t                op_i,
  output logic                    op_pop_o,
  input  wire logic               res_pop_i,
  output logic                    res_empty_o,
  output res_t                    res_o
);

  localparam int N_EFF      = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
  localparam int IDX_W      = $clog2(N_EFF);
  localparam int TRV_DEPTH  = 1 << (2 * IDX_W);
  localparam int ATTR_DEPTH = 1 << IDX_W;
  localparam int OCNT_W     = $clog2(OUT_DEPTH) + 1;
  localparam int EXT_W      = SUM_W - VAL_W;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] max_of(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [SUM_W-1:0] ext(input logic [VAL_W-1:0] v);
    return {{EXT_W{1'b0}}, v};
  endfunction

  // Tables
  logic [VAL_W-1:0]     trav_mem [TRV_DEPTH];
  logic [4*VAL_W-1:0]   attr_mem [ATTR_DEPTH];
  logic [VAL_W-1:0]     trav_rd_q;
  logic [4*VAL_W-1:0]   attr_rd_q;

  // Issue side route state
  logic [IDX_W-1:0]     prev_q;
  logic                 prev_ok_q;
  logic [1:0]           stops_q;

  // Compute stage
  logic                 s2_valid_q;
  logic                 s2_calc_q;
  logic                 s2_first_q;
  logic                 s2_trav_ok_q;
  logic                 s2_node_ok_q;
  logic                 s2_last_q;

  logic [SUM_W-1:0]     clock_q, clock_d;
  logic [SUM_W-1:0]     cost_q, cost_d;
  logic [SUM_W-1:0]     load_q, load_d;
  logic                 late_q, late_d;
  logic [VAL_W-1:0]     cap_q;

  logic                 issue;
  logic                 is_stop;
  logic                 room;
  logic [OCNT_W:0]      pend_sum;
  logic [OCNT_W-1:0]    out_count;
  logic                 out_full;
  logic                 res_push;
  res_t                 res_d;

  logic [VAL_W-1:0]     travel, wopen, wclose, serv, dem;
  logic [SUM_W-1:0]     arrive, clock_new, cost_new, load_new;
  logic                 late_new;

  // Reserve a result slot for a route's last stop still in flight.
  assign pend_sum = {1'b0, out_count} + (OCNT_W + 1)'(s2_valid_q && s2_last_q);
  assign room     = (pend_sum < (OCNT_W + 1)'(OUT_DEPTH));
  assign issue    = !op_empty_i && room;
  assign op_pop_o = issue;
  assign is_stop  = issue && (op_i.kind == OP_STOP);

  always_ff @(posedge clk_i) begin
    if (issue && (op_i.kind == OP_TRAVEL) && op_i.node_ok && op_i.peer_ok) begin
      trav_mem[{op_i.node[IDX_W-1:0], op_i.peer[IDX_W-1:0]}] <= op_i.data[0];
    end
    if (issue && (op_i.kind == OP_ATTR) && op_i.node_ok) begin
      attr_mem[op_i.node[IDX_W-1:0]] <= op_i.data;
    end
    if (is_stop) begin
      trav_rd_q <= trav_mem[{prev_q, op_i.node[IDX_W-1:0]}];
      attr_rd_q <= attr_mem[op_i.node[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      prev_ok_q    <= 1'b1;
      stops_q      <= '0;
      s2_valid_q   <= 1'b0;
      s2_calc_q    <= 1'b0;
      s2_first_q   <= 1'b0;
      s2_trav_ok_q <= 1'b0;
      s2_node_ok_q <= 1'b0;
      s2_last_q    <= 1'b0;
    end else begin
      s2_valid_q <= is_stop;
      if (is_stop) begin
        s2_calc_q    <= (stops_q != 2'd0);
        s2_first_q   <= (stops_q == 2'd1);
        s2_trav_ok_q <= op_i.node_ok && prev_ok_q;
        s2_node_ok_q <= op_i.node_ok;
        s2_last_q    <= op_i.last;
        if (op_i.last) begin
          prev_q    <= '0;
          prev_ok_q <= 1'b1;
          stops_q   <= '0;
        end else begin
          prev_q    <= op_i.node[IDX_W-1:0];
          prev_ok_q <= op_i.node_ok;
          stops_q   <= (stops_q != 2'd0) ? 2'd2 : 2'd1;
        end
      end
    end
  end

  // Out-of-range nodes read as zero.
  always_comb begin
    travel = s2_trav_ok_q ? trav_rd_q : '0;
    wopen  = s2_node_ok_q ? attr_rd_q[0*VAL_W +: VAL_W] : '0;
    wclose = s2_node_ok_q ? attr_rd_q[1*VAL_W +: VAL_W] : '0;
    serv   = s2_node_ok_q ? attr_rd_q[2*VAL_W +: VAL_W] : '0;
    dem    = s2_node_ok_q ? attr_rd_q[3*VAL_W +: VAL_W] : '0;

    if (s2_first_q) begin
      arrive = max_of(ext(wopen), ext(travel));
    end else begin
      arrive = max_of(sat_add(clock_q, ext(travel)), ext(wopen));
    end

    if (s2_calc_q) begin
      late_new  = late_q || (arrive > ext(wclose));
      clock_new = sat_add(arrive, ext(serv));
      cost_new  = sat_add(cost_q, ext(travel));
      load_new  = sat_add(load_q, ext(dem));
    end else begin
      late_new  = late_q;
      clock_new = clock_q;
      cost_new  = cost_q;
      load_new  = load_q;
    end

    res_d.cost   = cost_new;
    res_d.finish = clock_new;
    res_d.load   = load_new;
    if (late_new) begin
      res_d.status = ST_LATE;
    end else if (load_new > ext(cap_q)) begin
      res_d.status = ST_OVER;
    end else begin
      res_d.status = ST_OK;
    end

    res_push = s2_valid_q && s2_last_q;

    clock_d = clock_q;
    cost_d  = cost_q;
    load_d  = load_q;
    late_d  = late_q;
    if (s2_valid_q) begin
      if (s2_last_q) begin
        clock_d = '0;
        cost_d  = '0;
        load_d  = '0;
        late_d  = 1'b0;
      end else begin
        clock_d = clock_new;
        cost_d  = cost_new;
        load_d  = load_new;
        late_d  = late_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
      cost_q  <= '0;
      load_q  <= '0;
      late_q  <= 1'b0;
      cap_q   <= CAP_RESET;
    end else begin
      clock_q <= clock_d;
      cost_q  <= cost_d;
      load_q  <= load_d;
      late_q  <= late_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  rtwc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_d),
    .pop_i   (res_pop_i),
    .data_o  (res_o),
    .full_o  (out_full),
    .empty_o (res_empty_o),
    .count_o (out_count)
  );

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_stops_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stops_q != 2'd3)
    else $error("stop counter out of range");

  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_stop && op_i.last) |=> (s2_valid_q && s2_last_q))
    else $error("last stop lost between issue and compute");

  a_single_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_calc_q) |-> (cost_q == '0 && load_q == '0 && clock_q == '0 && !late_q))
    else $error("route state not clear at first stop");

endmodule

`default_nettype wire

/* src/route_time_window_check.sv */
`default_nettype none

// Route time-window and load checker. Load commands fill a travel-time matrix
// (MAX_NODES x MAX_NODES) and per-node open/close/service/demand tables; route
// stops then follow one per item, and the last stop of a route produces one
// result with status (time checked before capacity), cost, finish time and
// load, all unsigned Q24.8 and saturating. The block takes one item per cycle
// while the command queue has room: a 4-deep command queue sits between the
// decoder and the execution pipeline. A stop goes through a table-read stage
// and a compute stage; its result enters the output queue in the cycle after
// the stop leaves the command queue. With nothing queued ahead, an accepted
// stop is registered in the command queue, the table-read stage and the result
// queue before it shows on the result ports. The input stalls only while the
// command queue is full; the execution side holds a command while the 4-entry
// result queue has no free slot for a result still in flight. The running-time
// chain (add, max, compare, add) in the compute stage sets the clock. Tables
// have no reset and need no clearing pass; a stop must only read entries
// written beforehand. Nodes at or above MAX_NODES are ignored on writes and
// read as zero. Write the capacity register only while the block is idle.
module route_time_window_check
  import rtwc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [VAL_W-1:0]   cfg_wdata_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         command_i,
  input  wire logic [NODE_W-1:0]  node_i,
  input  wire logic [NODE_W-1:0]  peer_node_i,
  input  wire logic [VAL_W-1:0]   travel_value_i,
  input  wire logic [VAL_W-1:0]   window_open_i,
  input  wire logic [VAL_W-1:0]   window_close_i,
  input  wire logic [VAL_W-1:0]   service_duration_i,
  input  wire logic [VAL_W-1:0]   node_demand_i,
  input  wire logic               last_stop_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              status_o,
  output logic [SUM_W-1:0]        total_cost_o,
  output logic [SUM_W-1:0]        finish_time_o,
  output logic [SUM_W-1:0]        total_load_o
);

  logic op_valid;
  op_t  op_in;
  op_t  op_out;
  logic op_full;
  logic op_empty;
  logic op_pop;
  res_t res;

  rtwc_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .push_i             (push),
    .queue_full_i       (op_full),
    .command_i          (command_i),
    .node_i             (node_i),
    .peer_node_i        (peer_node_i),
    .travel_value_i     (travel_value_i),
    .window_open_i      (window_open_i),
    .window_close_i     (window_close_i),
    .service_duration_i (service_duration_i),
    .node_demand_i      (node_demand_i),
    .last_stop_i        (last_stop_i),
    .full_o             (full),
    .op_valid_o         (op_valid),
    .op_o               (op_in)
  );

  rtwc_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (MID_DEPTH)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_valid),
    .data_i  (op_in),
    .pop_i   (op_pop),
    .data_o  (op_out),
    .full_o  (op_full),
    .empty_o (op_empty),
    .count_o ()
  );

  rtwc_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_empty_i  (op_empty),
    .op_i        (op_out),
    .op_pop_o    (op_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign status_o      = res.status;
  assign total_cost_o  = res.cost;
  assign finish_time_o = res.finish;
  assign total_load_o  = res.load;

endmodule

`default_nettype wire
